// ===== rtl/nir_pkg.sv =====
// shared types and constants for the next index in value range block
`default_nettype none

package nir_pkg;

  localparam int unsigned NIR_DEPTH = 1024;
  localparam int unsigned POS_W     = 10;
  localparam int unsigned VAL_W     = 32;
  localparam int unsigned OP_W      = 2;

  localparam logic [OP_W-1:0] OP_CLEAR = 2'd0;
  localparam logic [OP_W-1:0] OP_LOAD  = 2'd1;
  localparam logic [OP_W-1:0] OP_QUERY = 2'd2;

  // controller to datapath
  typedef struct packed {
    logic cnt_clr;
    logic cnt_load;
    logic cnt_inc;
    logic bounds_load;
    logic mem_clr_wr;
    logic mem_load_wr;
    logic mem_rd;
    logic out_load;
    logic out_found;
  } nir_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic pos_ok;
    logic last;
    logic hit;
    logic out_free;
  } nir_sts_t;

endpackage

`default_nettype wire

// ===== rtl/nir_ctrl.sv =====
// controller state machine for clear sweep, load and query scan
`default_nettype none

module nir_ctrl
  import nir_pkg::*;
(
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            in_valid_i,
  output logic                 in_ready_o,
  input  wire logic [OP_W-1:0] op_i,
  input  wire nir_sts_t        sts_i,
  output nir_cmd_t             cmd_o
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_CLR  = 3'd1;
  localparam logic [2:0] S_RD   = 3'd2;
  localparam logic [2:0] S_CHK  = 3'd3;
  localparam logic [2:0] S_RES  = 3'd4;

  logic [2:0] state_q, state_d;
  logic       found_q, found_d;
  logic       accept;

  assign in_ready_o = (state_q == S_IDLE);
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    state_d = state_q;
    found_d = found_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          case (op_i)
            OP_CLEAR: begin
              cmd_o.cnt_clr = 1'b1;
              state_d       = S_CLR;
            end
            OP_LOAD: begin
              cmd_o.mem_load_wr = sts_i.pos_ok;
            end
            OP_QUERY: begin
              cmd_o.cnt_load    = 1'b1;
              cmd_o.bounds_load = 1'b1;
              if (sts_i.pos_ok) begin
                state_d = S_RD;
              end else begin
                found_d = 1'b0;
                state_d = S_RES;
              end
            end
            default: begin
              state_d = S_IDLE;
            end
          endcase
        end
      end
      S_CLR: begin
        cmd_o.mem_clr_wr = 1'b1;
        if (sts_i.last) begin
          state_d = S_IDLE;
        end else begin
          cmd_o.cnt_inc = 1'b1;
        end
      end
      S_RD: begin
        cmd_o.mem_rd = 1'b1;
        state_d      = S_CHK;
      end
      S_CHK: begin
        if (sts_i.hit) begin
          found_d = 1'b1;
          state_d = S_RES;
        end else if (sts_i.last) begin
          found_d = 1'b0;
          state_d = S_RES;
        end else begin
          cmd_o.cnt_inc = 1'b1;
          state_d       = S_RD;
        end
      end
      S_RES: begin
        if (sts_i.out_free) begin
          cmd_o.out_load  = 1'b1;
          cmd_o.out_found = found_q;
          state_d         = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLR;
      found_q <= 1'b0;
    end else begin
      state_q <= state_d;
      found_q <= found_d;
    end
  end

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |-> sts_i.out_free)
    else $error("result loaded while previous result pending");

  a_read_then_check: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_RD) |=> (state_q == S_CHK))
    else $error("memory read not followed by check");

  a_query_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && op_i == OP_QUERY) |=> (state_q != S_IDLE))
    else $error("query accepted without scan or result");

  a_single_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd_o.mem_clr_wr && cmd_o.mem_load_wr))
    else $error("clear sweep and load write collide");

endmodule

`default_nettype wire

// ===== rtl/nir_dp.sv =====
// datapath with value memory, scan counter, range compare and result register
`default_nettype none

module nir_dp
  import nir_pkg::*;
#(
  parameter int unsigned DEPTH = NIR_DEPTH
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire nir_cmd_t         cmd_i,
  output nir_sts_t              sts_o,
  input  wire logic [POS_W-1:0] position_i,
  input  wire logic [VAL_W-1:0] value_i,
  input  wire logic [VAL_W-1:0] range_low_i,
  input  wire logic [VAL_W-1:0] range_high_i,
  output logic                  out_valid_o,
  input  wire logic             out_ready_i,
  output logic                  out_found_o,
  output logic [POS_W-1:0]      out_pos_o
);

  localparam int unsigned AW = $clog2(DEPTH);

  // entry: valid mark in the top bit, value below
  logic [VAL_W:0]        mem [DEPTH];
  logic [VAL_W:0]        rd_q;
  logic [AW-1:0]         cnt_q;
  logic signed [VAL_W-1:0] low_q, high_q;
  logic signed [VAL_W-1:0] rd_val;
  logic                  out_valid_q;
  logic                  out_found_q;
  logic [POS_W-1:0]      out_pos_q;
  logic                  mem_we;
  logic [AW-1:0]         mem_waddr;
  logic [VAL_W:0]        mem_wdata;

  assign mem_we    = cmd_i.mem_clr_wr || cmd_i.mem_load_wr;
  assign mem_waddr = cmd_i.mem_load_wr ? AW'(position_i) : cnt_q;
  assign mem_wdata = cmd_i.mem_load_wr ? {1'b1, value_i} : '0;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (cmd_i.mem_rd) begin
      rd_q <= mem[cnt_q];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (cmd_i.cnt_clr) begin
      cnt_q <= '0;
    end else if (cmd_i.cnt_load) begin
      cnt_q <= AW'(position_i);
    end else if (cmd_i.cnt_inc) begin
      cnt_q <= cnt_q + AW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.bounds_load) begin
      low_q  <= $signed(range_low_i);
      high_q <= $signed(range_high_i);
    end
  end

  assign rd_val = $signed(rd_q[VAL_W-1:0]);

  assign sts_o.pos_ok   = 32'(position_i) < 32'(DEPTH);
  assign sts_o.last     = (cnt_q == AW'(DEPTH - 1));
  assign sts_o.hit      = rd_q[VAL_W] && (rd_val >= low_q) && (rd_val <= high_q);
  assign sts_o.out_free = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_found_q <= cmd_i.out_found;
      out_pos_q   <= cmd_i.out_found ? POS_W'(cnt_q) : '0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_found_o = out_found_q;
  assign out_pos_o   = out_pos_q;

endmodule

`default_nettype wire

// ===== rtl/next_index_in_value_range.sv =====
// Next index in value range: a table of DEPTH signed 32-bit values, each with
// a valid mark, held in one single-port-style memory. A load (tuser = 1) writes
// one entry. A clear (tuser = 0) sweeps the memory one entry per cycle; the same
// sweep runs right after reset, and no input transfer is taken until it ends. A
// query (tuser = 2) scans from the start position upward, reading each entry and
// then comparing it, until the first match or the last entry; a start at or
// past DEPTH answers not found without a scan. The result sits in an output
// register, so the next item is taken while it waits. Operation code 3 is
// accepted and dropped.
`default_nettype none

module next_index_in_value_range
  import nir_pkg::*;
#(
  parameter int unsigned DEPTH = NIR_DEPTH
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         s_tvalid_i,
  output logic              s_tready_o,
  // position[9:0], value[41:10], range_low[73:42], range_high[105:74], zero fill
  input  wire logic [111:0] s_tdata_i,
  // operation[1:0]
  input  wire logic [1:0]   s_tuser_i,
  output logic              m_tvalid_o,
  input  wire logic         m_tready_i,
  // match_position[9:0], zero fill
  output logic [15:0]       m_tdata_o,
  // found[0]
  output logic [0:0]        m_tuser_o
);

  nir_cmd_t         cmd;
  nir_sts_t         sts;
  logic [POS_W-1:0] out_pos;
  logic             out_found;

  nir_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_tvalid_i),
    .in_ready_o (s_tready_o),
    .op_i       (s_tuser_i),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  nir_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .position_i   (s_tdata_i[9:0]),
    .value_i      (s_tdata_i[41:10]),
    .range_low_i  (s_tdata_i[73:42]),
    .range_high_i (s_tdata_i[105:74]),
    .out_valid_o  (m_tvalid_o),
    .out_ready_i  (m_tready_i),
    .out_found_o  (out_found),
    .out_pos_o    (out_pos)
  );

  assign m_tdata_o = {6'd0, out_pos};
  assign m_tuser_o = out_found;

endmodule

`default_nettype wire

// ===== tb/next_index_in_value_range_tb.sv =====
// testbench for next_index_in_value_range: directed table then random transfers, checked by a model
module next_index_in_value_range_tb;
  import nir_pkg::*;

  localparam int unsigned DEPTH = NIR_DEPTH;
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
  localparam int unsigned N_RANDOM = 1250;
  localparam int unsigned IDLE_PCT = 19;
  localparam int unsigned QUIET_FROM = 500;
  localparam int unsigned QUIET_TO = 700;
  localparam int unsigned DRAIN_CYCLES = 2 * DEPTH + 32;
  localparam longint unsigned CYCLE_LIMIT = longint'(N_RANDOM + 100) * (2 * DEPTH + 64) * 4;
  localparam int unsigned ANS_SLOTS = 16;
  localparam int unsigned ROW_SLOTS = 32;
  localparam logic signed [VAL_W-1:0] VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};
  localparam logic signed [VAL_W-1:0] VAL_MAX = {1'b0, {(VAL_W-1){1'b1}}};

  typedef struct {
    logic [OP_W-1:0]         op;
    logic [POS_W-1:0]        pos;
    logic signed [VAL_W-1:0] value;
    logic signed [VAL_W-1:0] lo;
    logic signed [VAL_W-1:0] hi;
  } item_t;

  typedef struct {
    logic             found;
    logic [POS_W-1:0] pos;
  } answer_t;

  typedef struct {
    item_t   it;
    bit      typed;
    answer_t ans;
  } row_t;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_tvalid_i = 1'b0;
  logic         s_tready_o;
  logic [111:0] s_tdata_i = '0;
  logic [1:0]   s_tuser_i = '0;
  logic         m_tvalid_o;
  logic         m_tready_i = 1'b0;
  logic [15:0]  m_tdata_o;
  logic [0:0]   m_tuser_o;

  logic signed [VAL_W-1:0] shadow_value [DEPTH];
  bit                      shadow_valid [DEPTH];
  answer_t                 pending_answers [ANS_SLOTS];
  int unsigned             ans_wr = 0;
  int unsigned             ans_rd = 0;
  row_t                    dir_table [ROW_SLOTS];
  int unsigned             n_rows = 0;
  int                      errors = 0;
  bit                      quiet = 1'b0;
  longint unsigned         cycles = 0;

  next_index_in_value_range DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_tvalid_i),
    .s_tready_o (s_tready_o),
    .s_tdata_i  (s_tdata_i),
    .s_tuser_i  (s_tuser_i),
    .m_tvalid_o (m_tvalid_o),
    .m_tready_i (m_tready_i),
    .m_tdata_o  (m_tdata_o),
    .m_tuser_o  (m_tuser_o)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  function automatic void store_answer(input answer_t a);
    pending_answers[ans_wr % ANS_SLOTS] = a;
    ans_wr++;
  endfunction

  function automatic answer_t take_answer();
    answer_t a;
    a = pending_answers[ans_rd % ANS_SLOTS];
    ans_rd++;
    return a;
  endfunction

  // updates the shadow table, returns 1 when the item answers
  function automatic bit lookup_next_in_range(input item_t it, output answer_t ans);
    ans = '{1'b0, '0};
    case (it.op)
      OP_CLEAR: begin
        foreach (shadow_valid[j]) shadow_valid[j] = 1'b0;
        return 1'b0;
      end
      OP_LOAD: begin
        if (it.pos < DEPTH) begin
          shadow_value[it.pos] = it.value;
          shadow_valid[it.pos] = 1'b1;
        end
        return 1'b0;
      end
      OP_QUERY: begin
        for (int j = it.pos; j < DEPTH; j++) begin
          if (shadow_valid[j] && shadow_value[j] >= it.lo && shadow_value[j] <= it.hi) begin
            ans.found = 1'b1;
            ans.pos = POS_W'(j);
            break;
          end
        end
        return 1'b1;
      end
      default: return 1'b0;
    endcase
  endfunction

  function automatic row_t dir_row(input logic [OP_W-1:0] op, input int pos,
                                   input logic signed [VAL_W-1:0] value,
                                   input logic signed [VAL_W-1:0] lo,
                                   input logic signed [VAL_W-1:0] hi,
                                   input bit typed = 1'b0, input bit found = 1'b0,
                                   input int mpos = 0);
    row_t r;
    r.it = '{op, POS_W'(pos), value, lo, hi};
    r.typed = typed;
    r.ans = '{found, POS_W'(mpos)};
    return r;
  endfunction

  function automatic void add_row(input row_t r);
    dir_table[n_rows] = r;
    n_rows++;
  endfunction

  function automatic logic signed [VAL_W-1:0] pick_value();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 55) return VAL_W'($urandom_range(16)) - VAL_W'(8);
    if (r < 75) begin
      case ($urandom_range(3))
        0: return VAL_MIN;
        1: return VAL_MAX;
        2: return '0;
        default: return '1;
      endcase
    end
    return $urandom();
  endfunction

  // mostly the top window keeps scans short
  function automatic logic [POS_W-1:0] pick_position();
    if ($urandom_range(99) < 80) return POS_W'(DEPTH - 64 + $urandom_range(63));
    return POS_W'($urandom_range(DEPTH - 1));
  endfunction

  function automatic item_t random_item();
    item_t it;
    int unsigned r;
    logic signed [VAL_W-1:0] t;
    r = $urandom_range(999);
    if (r < 15) it.op = OP_CLEAR;
    else if (r < 35) it.op = OP_UNUSED;
    else if (r < 480) it.op = OP_LOAD;
    else it.op = OP_QUERY;
    it.pos = pick_position();
    it.value = pick_value();
    it.lo = pick_value();
    it.hi = pick_value();
    if (it.lo > it.hi && $urandom_range(99) < 70) begin
      t = it.lo;
      it.lo = it.hi;
      it.hi = t;
    end
    return it;
  endfunction

  task automatic send_item(input item_t it, input bit typed, input answer_t typed_ans);
    answer_t ans;
    bit has_ans;
    @(negedge clk_i);
    while (!quiet && $urandom_range(99) < IDLE_PCT) begin
      s_tvalid_i = 1'b0;
      @(negedge clk_i);
    end
    s_tvalid_i = 1'b1;
    s_tuser_i = it.op;
    s_tdata_i = {6'b0, it.hi, it.lo, it.value, it.pos};
    do @(posedge clk_i); while (!s_tready_o);
    has_ans = lookup_next_in_range(it, ans);
    if (has_ans) store_answer(typed ? typed_ans : ans);
  endtask

  always @(negedge clk_i) m_tready_i = quiet || ($urandom_range(99) >= IDLE_PCT);

  always @(posedge clk_i) begin
    answer_t exp_ans;
    if (rst_ni && m_tvalid_o && m_tready_i) begin
      if (ans_wr == ans_rd) begin
        $error("unexpected transfer: found %0d, match_position %0d", m_tuser_o[0],
               m_tdata_o[POS_W-1:0]);
        errors++;
      end else begin
        exp_ans = take_answer();
        if (m_tuser_o[0] !== exp_ans.found) begin
          $error("found: expected %0d, got %0d", exp_ans.found, m_tuser_o[0]);
          errors++;
        end
        if (m_tdata_o[POS_W-1:0] !== exp_ans.pos) begin
          $error("match_position: expected %0d, got %0d", exp_ans.pos, m_tdata_o[POS_W-1:0]);
          errors++;
        end
      end
    end
  end

  initial begin
    item_t it;
    answer_t none;
    int unsigned counted;
    none = '{1'b0, '0};
    foreach (shadow_value[j]) begin
      shadow_value[j] = '0;
      shadow_valid[j] = 1'b0;
    end
    repeat (2) @(negedge clk_i);
    rst_ni = 1'b1;

    add_row(dir_row(OP_QUERY, 0, 0, VAL_MIN, VAL_MAX, 1, 0, 0));
    add_row(dir_row(OP_LOAD, 0, VAL_MIN, 0, 0));
    add_row(dir_row(OP_LOAD, DEPTH - 1, VAL_MAX, 0, 0));
    add_row(dir_row(OP_LOAD, 5, 0, 0, 0));
    add_row(dir_row(OP_LOAD, 5, -1, 0, 0));
    add_row(dir_row(OP_QUERY, 0, 0, VAL_MIN, VAL_MIN, 1, 1, 0));
    add_row(dir_row(OP_QUERY, 1, 0, VAL_MIN, VAL_MAX, 1, 1, 5));
    add_row(dir_row(OP_QUERY, 1, 0, 0, 0));
    add_row(dir_row(OP_QUERY, 6, 0, VAL_MAX, VAL_MAX, 1, 1, DEPTH - 1));
    add_row(dir_row(OP_QUERY, DEPTH - 1, 0, VAL_MIN, VAL_MAX, 1, 1, DEPTH - 1));
    add_row(dir_row(OP_QUERY, 0, 0, 1, 0, 1, 0, 0));
    add_row(dir_row(OP_QUERY, 0, 0, VAL_MAX, VAL_MIN, 1, 0, 0));
    add_row(dir_row(OP_UNUSED, DEPTH - 1, -1, -1, -1));
    add_row(dir_row(OP_QUERY, 2, -1, -1, -1, 1, 1, 5));
    add_row(dir_row(OP_QUERY, 6, 0, -1, VAL_MAX - 1));
    add_row(dir_row(OP_CLEAR, DEPTH - 1, -1, -1, -1));
    add_row(dir_row(OP_QUERY, 0, 0, VAL_MIN, VAL_MAX, 1, 0, 0));
    add_row(dir_row(OP_LOAD, 512, 32'hAAAA_AAAA, 0, 0));
    add_row(dir_row(OP_LOAD, DEPTH - 1, 32'h5555_5555, 0, 0));
    add_row(dir_row(OP_QUERY, 0, 0, VAL_MIN, VAL_MAX, 1, 1, 512));
    add_row(dir_row(OP_QUERY, 513, 0, VAL_MIN, VAL_MAX, 1, 1, DEPTH - 1));
    add_row(dir_row(OP_QUERY, 600, 0, 32'h5555_5555, 32'h5555_5555));
    add_row(dir_row(OP_LOAD, 300, 0, 0, 0));
    add_row(dir_row(OP_QUERY, 301, 0, 0, 0));
    add_row(dir_row(OP_QUERY, DEPTH - 2, 0, VAL_MIN, 0));

    for (int unsigned i = 0; i < n_rows; i++) begin
      send_item(dir_table[i].it, dir_table[i].typed, dir_table[i].ans);
    end

    counted = 0;
    while (counted < N_RANDOM) begin
      quiet = (counted >= QUIET_FROM && counted < QUIET_TO);
      it = random_item();
      send_item(it, 1'b0, none);
      if (it.op != OP_UNUSED) counted++;
    end
    quiet = 1'b0;
    @(negedge clk_i);
    s_tvalid_i = 1'b0;

    while (ans_wr != ans_rd) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
